[rtl/tsh_pkg.sv]
// Shared types and constants for the thermostat / LED progress bar block.
// No dependencies.
package tsh_pkg;

  // T(Q8) = TempOffset - round(DivNum / sample)
  localparam logic [31:0] TempOffset = 32'd42737;
  localparam int unsigned DivNumW    = 26;
  localparam logic [DivNumW-1:0] DivNum = 26'd44134272;
  localparam int unsigned DivSteps   = DivNumW;
  localparam int unsigned DivCntW    = $clog2(DivSteps);

  localparam int unsigned SampleW    = 12;
  localparam int unsigned SetpointW  = 24;
  localparam int unsigned BandW      = 16;
  localparam int unsigned CfgDataW   = 24;
  localparam int unsigned BarW       = 16;

  localparam logic [SetpointW-1:0] SetpointReset = 24'd28160;
  localparam logic [BandW-1:0]     BandReset     = 16'd640;
  localparam logic [BarW-1:0]      BarReset      = 16'h0003;

  // config register indexes
  localparam logic CfgSetpoint = 1'b0;
  localparam logic CfgBand     = 1'b1;

  // item kinds
  localparam logic FuncSample = 1'b0;
  localparam logic FuncButton = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StTemp,
    StPrep,
    StUpd
  } ctrl_state_e;

  typedef struct packed {
    logic load;      // request accepted, capture payload
    logic div_step;  // one restoring-division step
    logic temp_ld;   // form temperature from quotient
    logic prep_ld;   // heater / threshold / accumulator staging
    logic commit;    // update state, load output register
  } tsh_cmd_t;

endpackage

[rtl/tsh_ctrl.sv]
// Sequencer for the thermostat block: handshakes, division step count,
// output valid. Depends on tsh_pkg.
module tsh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              func_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tsh_pkg::tsh_cmd_t cmd_o
);
  import tsh_pkg::*;

  ctrl_state_e         state_q, state_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = (func_i == FuncButton) ? StUpd : StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = StTemp;
        end
      end
      StTemp: begin
        cmd_o.temp_ld = 1'b1;
        state_d       = StPrep;
      end
      StPrep: begin
        cmd_o.prep_ld = 1'b1;
        state_d       = StUpd;
      end
      StUpd: begin
        // wait until the output register can take the result
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = cmd_o.commit || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/tsh_dpath.sv]
// Datapath: config registers, restoring divider, thermostat and bar state,
// output register. Depends on tsh_pkg.
module tsh_dpath #(
  parameter int unsigned LED_COUNT = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tsh_pkg::tsh_cmd_t                cmd_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [tsh_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             func_i,
  input  logic [tsh_pkg::SampleW-1:0]      adc_sample_i,
  input  logic                             button_level_i,
  output logic                             heater_on_o,
  output logic signed [31:0]               temperature_o,
  output logic [tsh_pkg::BarW-1:0]         led_pattern_o,
  output logic                             led_update_o
);
  import tsh_pkg::*;

  localparam int unsigned CntW = $clog2(LED_COUNT + 1);

  // config
  logic signed [SetpointW-1:0] sp_q;
  logic [BandW-1:0]            band_q;

  // captured request
  logic                func_q, button_q;
  logic [SampleW-1:0]  div_q;

  // divider
  logic [DivNumW-1:0]  quo_q;
  logic [SampleW-1:0]  rem_q;
  logic [SampleW:0]    trial;
  logic                qbit;

  // architectural state
  logic                heater_q;
  logic signed [31:0]  prev_q, acc_q, thr_q;
  logic [BarW-1:0]     bar_q;
  logic [CntW-1:0]     cnt_q;

  // staging
  logic signed [31:0]  temp_q, temp_d;
  logic                heat_st_q, heat_st_d;
  logic signed [31:0]  thr_st_q, thr_st_d, acc_st_q, acc_st_d;

  logic signed [33:0]  sp34, band34, t34, p34, a34, hi34, lo34, diff34, adj34, sum34;
  logic signed [33:0]  thr34;
  logic [5:0]          bit_idx;
  logic [BarW-1:0]     bar_set;
  logic                issue;

  localparam logic signed [33:0] Max34 = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] Min34 = 34'sh3_8000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= SetpointReset;
      band_q <= BandReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgSetpoint) begin
        sp_q <= cfg_data_i[SetpointW-1:0];
      end else begin
        band_q <= cfg_data_i[BandW-1:0];
      end
    end
  end

  // restoring division, one quotient bit per step
  assign trial = {rem_q, quo_q[DivNumW-1]};
  assign qbit  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      button_q <= button_level_i;
      div_q    <= adc_sample_i;
      quo_q    <= DivNum + DivNumW'(adc_sample_i >> 1);
      rem_q    <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? SampleW'(trial - {1'b0, div_q}) : trial[SampleW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], qbit};
    end
  end

  // a zero sample pins the temperature to the most negative value
  assign temp_d = (div_q == '0) ? 32'sh8000_0000 : $signed(TempOffset - {6'd0, quo_q});

  assign sp34   = {{10{sp_q[SetpointW-1]}}, sp_q};
  assign band34 = {18'd0, band_q};
  assign t34    = {{2{temp_q[31]}}, temp_q};
  assign p34    = {{2{prev_q[31]}}, prev_q};
  assign a34    = {{2{acc_q[31]}}, acc_q};
  assign hi34   = sp34 + band34;
  assign lo34   = sp34 - band34;
  assign diff34 = sp34 - t34;
  assign adj34  = diff34[33] ? diff34 + 34'sd15 : diff34;  // truncate toward zero
  assign thr34  = adj34 >>> 4;
  assign sum34  = a34 + t34 - p34;

  always_comb begin
    if (t34 > hi34) begin
      heat_st_d = 1'b0;
    end else if (t34 < lo34) begin
      heat_st_d = 1'b1;
    end else begin
      heat_st_d = heater_q;
    end
    thr_st_d = (prev_q == 32'sd0) ? thr34[31:0] : thr_q;
    if (sum34 > Max34) begin
      acc_st_d = Max34[31:0];
    end else if (sum34 < Min34) begin
      acc_st_d = Min34[31:0];
    end else begin
      acc_st_d = sum34[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.temp_ld) begin
      temp_q <= temp_d;
    end
    if (cmd_i.prep_ld) begin
      heat_st_q <= heat_st_d;
      thr_st_q  <= thr_st_d;
      acc_st_q  <= acc_st_d;
    end
  end

  // next bar bit lands at index count+1, dropped beyond the bar word
  assign bit_idx = 6'(cnt_q) + 6'd1;
  always_comb begin
    for (int k = 0; k < BarW; k++) begin
      bar_set[k] = (bit_idx == 6'(k));
    end
  end

  assign issue = (func_q == FuncSample) && (acc_st_q >= thr_st_q) &&
                 (cnt_q < CntW'(LED_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q <= 1'b0;
      prev_q   <= '0;
      acc_q    <= '0;
      thr_q    <= '0;
      bar_q    <= BarReset;
      cnt_q    <= CntW'(1);
    end else if (cmd_i.commit) begin
      if (func_q == FuncButton) begin
        heater_q <= button_q;
      end else begin
        heater_q <= heat_st_q;
        thr_q    <= thr_st_q;
        prev_q   <= temp_q;
        if (issue) begin
          acc_q <= '0;
          bar_q <= bar_q | bar_set;
          cnt_q <= cnt_q + 1'b1;
        end else begin
          acc_q <= acc_st_q;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (func_q == FuncButton) begin
        heater_on_o   <= button_q;
        temperature_o <= prev_q;
        led_pattern_o <= '0;
        led_update_o  <= 1'b0;
      end else begin
        heater_on_o   <= heat_st_q;
        temperature_o <= temp_q;
        led_pattern_o <= issue ? bar_q : '0;
        led_update_o  <= issue;
      end
    end
  end

endmodule

[rtl/thermostat_hysteresis_progress_bar.sv]
// Thermostat with hysteresis and LED progress bar, top level.
// ADC sample: the 26-step restoring divider forms the reciprocal term, then the
// temperature and staging registers load. Button request: skips the divider.
// Each result commits once the output register is free; no new accept until then.
// Reset (rst_ni low, async): idle, heater off, bar word 0x0003, config at defaults.
module thermostat_hysteresis_progress_bar #(
  parameter int unsigned LED_COUNT = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [tsh_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [tsh_pkg::SampleW-1:0]  adc_sample_i,
  input  logic                         button_level_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         heater_on_o,
  output logic signed [31:0]           temperature_o,
  output logic [tsh_pkg::BarW-1:0]     led_pattern_o,
  output logic                         led_update_o
);
  import tsh_pkg::*;

  tsh_cmd_t cmd;

  tsh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tsh_dpath #(
    .LED_COUNT (LED_COUNT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .adc_sample_i   (adc_sample_i),
    .button_level_i (button_level_i),
    .heater_on_o    (heater_on_o),
    .temperature_o  (temperature_o),
    .led_pattern_o  (led_pattern_o),
    .led_update_o   (led_update_o)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for thermostat_hysteresis_progress_bar.
// Drives sample and button requests with bursty timing and checks every readout.
// Depends on tsh_pkg and the thermostat_hysteresis_progress_bar RTL.
module tb;
  import tsh_pkg::*;

  localparam longint TempOffsetQ8  = 42737;
  localparam longint RecipNumQ8    = 44134272;
  localparam int     BarLen        = 16;
  localparam int     IntMax        = 32'sh7fff_ffff;
  localparam int     IntMin        = 32'sh8000_0000;
  localparam int     ItemsPerPhase = 190;
  localparam int     DrainCycles   = 40;
  localparam int     HoldAfter     = 400;
  localparam int     HoldCycles    = 400;

  typedef struct packed {
    logic                  func;
    logic [SampleW-1:0]    sample;
    logic                  button;
  } sensor_req_t;

  typedef struct packed {
    logic                  heater_on;
    logic signed [31:0]    temperature;
    logic [BarW-1:0]       led_pattern;
    logic                  led_update;
  } readout_t;

  typedef enum logic [1:0] {
    RxOpen,
    RxRandom,
    RxPeriodic,
    RxSparse
  } rx_mode_e;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic                 cfg_idx_i      = CfgSetpoint;
  logic [CfgDataW-1:0]  cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic                 func_i         = FuncSample;
  logic [SampleW-1:0]   adc_sample_i   = '0;
  logic                 button_level_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic                 heater_on_o;
  logic signed [31:0]   temperature_o;
  logic [BarW-1:0]      led_pattern_o;
  logic                 led_update_o;

  thermostat_hysteresis_progress_bar DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .adc_sample_i   (adc_sample_i),
    .button_level_i (button_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .heater_on_o    (heater_on_o),
    .temperature_o  (temperature_o),
    .led_pattern_o  (led_pattern_o),
    .led_update_o   (led_update_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  class thermo_scoreboard;
    int          setpoint;
    int unsigned band;
    logic        heater;
    int          last_temp;
    int          drift;
    int          step_size;
    logic [15:0] bar_word;
    int unsigned bar_count;
    readout_t    pending[$];
    int unsigned errors;
    int unsigned n_noted;

    function void clear();
      setpoint  = {{8{SetpointReset[SetpointW-1]}}, SetpointReset};
      band      = 32'(BandReset);
      heater    = 1'b0;
      last_temp = 0;
      drift     = 0;
      step_size = 0;
      bar_word  = BarReset;
      bar_count = 1;
      pending.delete();
      errors    = 0;
      n_noted   = 0;
    endfunction

    function void set_regs(logic [SetpointW-1:0] sp, logic [BandW-1:0] bw);
      setpoint = {{8{sp[SetpointW-1]}}, sp};
      band     = 32'(bw);
    endfunction

    function int clamp32(longint v);
      if (v > longint'(IntMax)) return IntMax;
      if (v < longint'(IntMin)) return IntMin;
      return int'(v);
    endfunction

    // Q8 degF from the divider reading, quotient rounded half up
    function int temp_of(logic [SampleW-1:0] s);
      longint q;
      if (s == 0) return IntMin;
      q = (RecipNumQ8 + longint'(s / 2)) / longint'(s);
      return clamp32(TempOffsetQ8 - q);
    endfunction

    function void note_request(sensor_req_t it);
      readout_t r;
      longint   t;
      r.led_pattern = '0;
      r.led_update  = 1'b0;
      n_noted++;
      if (it.func == FuncButton) begin
        heater        = it.button;
        r.temperature = last_temp;
      end else begin
        t = longint'(temp_of(it.sample));
        if (t > longint'(setpoint) + longint'(band)) heater = 1'b0;
        else if (t < longint'(setpoint) - longint'(band)) heater = 1'b1;
        // threshold only refreshes while the last temperature is exactly zero
        if (last_temp == 0) step_size = clamp32((longint'(setpoint) - t) / 16);
        drift = clamp32(longint'(drift) + t - longint'(last_temp));
        if (drift >= step_size && bar_count < BarLen) begin
          r.led_pattern = bar_word;
          r.led_update  = 1'b1;
          bar_word     |= 16'(32'd1 << (bar_count + 1));
          bar_count++;
          drift = 0;
        end
        last_temp     = int'(t);
        r.temperature = last_temp;
      end
      r.heater_on = heater;
      pending.push_back(r);
    endfunction

    function void check_result(readout_t got);
      readout_t want;
      if (pending.size() == 0) begin
        $error("readout with no request outstanding, temperature %0d", got.temperature);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.heater_on !== want.heater_on) begin
        $error("heater_on: expected %0d, got %0d", want.heater_on, got.heater_on);
        errors++;
      end
      if (got.temperature !== want.temperature) begin
        $error("temperature: expected %0d, got %0d", want.temperature, got.temperature);
        errors++;
      end
      if (got.led_pattern !== want.led_pattern) begin
        $error("led_pattern: expected 0x%04h, got 0x%04h", want.led_pattern, got.led_pattern);
        errors++;
      end
      if (got.led_update !== want.led_update) begin
        $error("led_update: expected %0d, got %0d", want.led_update, got.led_update);
        errors++;
      end
    endfunction
  endclass

  thermo_scoreboard board;
  sensor_req_t      stim_q[$];

  function automatic sensor_req_t sample_item(logic [SampleW-1:0] s);
    sensor_req_t it;
    it.func   = FuncSample;
    it.sample = s;
    it.button = 1'b0;
    return it;
  endfunction

  function automatic sensor_req_t button_item(logic b);
    sensor_req_t it;
    it.func   = FuncButton;
    it.sample = '1;
    it.button = b;
    return it;
  endfunction

  // mostly plain samples plus some button requests, with zero, tiny and near-full readings weighted up
  function automatic sensor_req_t random_item();
    sensor_req_t it;
    int unsigned pick;
    pick      = $urandom_range(99);
    it.func   = (pick < 15) ? FuncButton : FuncSample;
    it.button = 1'($urandom_range(1));
    it.sample = SampleW'($urandom);
    if (pick >= 15 && pick < 20) it.sample = '0;
    else if (pick >= 20 && pick < 30) it.sample = SampleW'($urandom_range(40, 1));
    else if (pick >= 30 && pick < 38) it.sample = SampleW'($urandom_range(4095, 4000));
    return it;
  endfunction

  task automatic program_regs(input logic [SetpointW-1:0] sp, input logic [BandW-1:0] bw);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgSetpoint;
    cfg_data_i <= sp;
    @(posedge clk_i);
    cfg_idx_i  <= CfgBand;
    cfg_data_i <= {{(CfgDataW-BandW){1'b0}}, bw};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    board.set_regs(sp, bw);
  endtask

  task automatic send_request(input sensor_req_t it);
    in_valid_i     <= 1'b1;
    func_i         <= it.func;
    adc_sample_i   <= it.sample;
    button_level_i <= it.button;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    board.note_request(it);
  endtask

  task automatic run_stim();
    int unsigned burst_left;
    int unsigned gap;
    sensor_req_t it;
    burst_left = 0;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(20, 1);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      send_request(it);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin : rx_side
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned cyc;
    bit          hold_done;
    logic        take;
    readout_t    got;
    mode      = RxOpen;
    mode_left = 50;
    hold_left = 0;
    cyc       = 0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (out_valid_o && out_ready_i) begin
        got.heater_on   = heater_on_o;
        got.temperature = temperature_o;
        got.led_pattern = led_pattern_o;
        got.led_update  = led_update_o;
        board.check_result(got);
      end
      // one long back-pressure window while requests keep coming
      if (!hold_done && board.n_noted >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(3));
        mode_left = $urandom_range(200, 20);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case (mode)
          RxOpen:     take = 1'b1;
          RxRandom:   take = 1'($urandom_range(1));
          RxPeriodic: take = (cyc % 4 == 0);
          default:    take = ($urandom_range(3) == 0);
        endcase
      end
      out_ready_i <= take;
    end
  end

  initial begin : main_seq
    board = new();
    board.clear();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // setpoint below the first reading gives a negative step, so the bar fills fast
    program_regs(24'd16000, 16'd640);
    stim_q.push_back(sample_item(12'd2048));
    stim_q.push_back(sample_item(12'd4095));
    stim_q.push_back(sample_item(12'd1));
    stim_q.push_back(sample_item(12'd0));
    stim_q.push_back(sample_item(12'd4095));
    stim_q.push_back(button_item(1'b1));
    stim_q.push_back(button_item(1'b0));
    stim_q.push_back(sample_item(12'd2048));
    stim_q.push_back(sample_item(12'd1));
    stim_q.push_back(sample_item(12'd4095));
    // steady readings: top bit drops off the 16-bit word, then the bar is full
    repeat (13) stim_q.push_back(sample_item(12'd4095));
    stim_q.push_back(button_item(1'b1));
    run_stim();
    wait_idle();

    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1:       program_regs(24'h80_0000, 16'h0000);
        2:       program_regs(24'h7f_ffff, 16'hffff);
        3:       program_regs(24'd0, 16'($urandom_range(3000)));
        4:       program_regs(24'(28160 + $urandom_range(16000) - 8000),
                              16'($urandom_range(3000)));
        default: program_regs(24'($urandom), 16'($urandom));
      endcase
      repeat (ItemsPerPhase) stim_q.push_back(random_item());
      run_stim();
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
rtl/tsh_pkg.sv
rtl/tsh_ctrl.sv
rtl/tsh_dpath.sv
rtl/thermostat_hysteresis_progress_bar.sv
tb/tb.sv
